### rtl/block_decomposed_range_sum_unit_macros.svh
// assertion macros for the range sum unit
`ifndef BLOCK_DECOMPOSED_RANGE_SUM_UNIT_MACROS_SVH
`define BLOCK_DECOMPOSED_RANGE_SUM_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clock edge out of reset
`define BDRS_ASSERT_NOW(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error("bdrs assertion failed");

// next-cycle implication
`define BDRS_ASSERT_NEXT(lbl, ant, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error("bdrs assertion failed");

`else

`define BDRS_ASSERT_NOW(lbl, ant, cons)
`define BDRS_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

### rtl/bdrs_pkg.sv
package bdrs_pkg;

   // array geometry
   localparam int ELEMENTS   = 1024;
   localparam int BLK_LOG2   = 5;
   localparam int BLOCK_SIZE = 1 << BLK_LOG2;
   localparam int GROUPS     = (ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

   // transaction field widths
   localparam int POS_W   = 10;
   localparam int END_W   = 11;
   localparam int VAL_W   = 32;
   localparam int TOTAL_W = 42;

   // derived internal widths
   localparam int SUM_W  = VAL_W + BLK_LOG2;
   localparam int ADDR_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
   localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int CUR_W  = END_W;
   localparam int STEP_W = CUR_W + 1;

   // operation codes
   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_SUM    = 1'b1;

endpackage

### rtl/bdrs_req_if.sv
interface bdrs_req_if
   import bdrs_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [POS_W-1:0]         position;
   logic [END_W-1:0]         range_end;
   logic signed [VAL_W-1:0]  value;

   modport source (output valid, output op, output position, output range_end,
                   output value, input ready);
   modport sink   (input valid, input op, input position, input range_end,
                   input value, output ready);
endinterface

### rtl/bdrs_rsp_if.sv
interface bdrs_rsp_if
   import bdrs_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [TOTAL_W-1:0]  total;
   logic                       range_error;

   modport source (output valid, output total, output range_error, input ready);
   modport sink   (input valid, input total, input range_error, output ready);
endinterface

### rtl/block_decomposed_range_sum_unit.sv
// range sum unit: element array plus one running sum per group of 32 elements
// req_chan carries assign (op 0: write value at position) and sum (op 1:
// total over [position, range_end)) transactions; rsp_chan returns one
// transaction per sum, none per assign
// an assign goes through accept, memory read, then write-back of element and
// group sum
// a sum accumulates n memory reads between accept and the result register,
// n being the number of reads of the walk (single elements up to a group
// boundary, whole group sums, then the remaining elements); n is at most 92,
// one read per cycle through the element and group-sum read ports
// an empty range needs no read and reaches the result register through S_QUERY
// as soon as the output register is free
// a reversed or overlong range returns zero with range_error set, also through
// S_QUERY without any read
// the result sits in an output register, so the next transaction is taken
// while the previous result waits; a sum that finishes while rsp_chan still
// stalls holds until the output register frees
// reset starts a clearing pass over all 1024 elements that zeroes both memories;
// req_chan.ready stays low until it is done
`include "block_decomposed_range_sum_unit_macros.svh"

module block_decomposed_range_sum_unit
   import bdrs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   bdrs_req_if.sink    req_chan,
   bdrs_rsp_if.source  rsp_chan
);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_ASG_RD = 5'b00100,
      S_ASG_WR = 5'b01000,
      S_QUERY  = 5'b10000
   } state_type;

   // state storage
   logic [VAL_W-1:0] element_mem [ELEMENTS];
   logic [SUM_W-1:0] sum_mem     [GROUPS];

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [CUR_W-1:0]   cur_ff, cur_in;
   logic [CUR_W-1:0]   end_ff, end_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic               err_ff, err_in;
   logic [TOTAL_W-1:0] acc_ff, acc_in;
   logic               pend_ff, pend_in;
   logic               kind_ff, kind_in;
   logic [VAL_W-1:0]   elem_rd_ff;
   logic [SUM_W-1:0]   sum_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               range_error_ff, range_error_in;

   // memory port controls
   logic              elem_we;
   logic [ADDR_W-1:0] elem_waddr;
   logic [VAL_W-1:0]  elem_wdata;
   logic [ADDR_W-1:0] elem_raddr;
   logic              sum_we;
   logic [GRP_W-1:0]  sum_waddr;
   logic [SUM_W-1:0]  sum_wdata;
   logic [GRP_W-1:0]  sum_raddr;

   // walk decode
   logic              req_fire;
   logic              cur_lt_end;
   logic              cur_aligned;
   logic              group_fits;
   logic              take_elem;
   logic              take_grp;
   logic              walk_done;
   logic              out_free;
   logic              finish;
   logic [ADDR_W-1:0] cur_addr;
   logic [GRP_W-1:0]  cur_grp;
   logic [TOTAL_W-1:0] addend;
   logic [SUM_W-1:0]  old_ext;
   logic [SUM_W-1:0]  new_ext;

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign req_fire             = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.total       = total_ff;
   assign rsp_chan.range_error = range_error_ff;

   assign cur_addr = cur_ff[ADDR_W-1:0];
   assign cur_grp  = GRP_W'(cur_ff >> BLK_LOG2);

   // walk step: single element while off a group boundary or when a whole
   // group would overshoot range_end, else one group sum
   assign cur_lt_end  = (cur_ff < end_ff);
   assign cur_aligned = (cur_ff[BLK_LOG2-1:0] == '0);
   assign group_fits  = ((STEP_W'(cur_ff) + STEP_W'(BLOCK_SIZE)) <= STEP_W'(end_ff));
   assign take_elem   = !err_ff && cur_lt_end && (!cur_aligned || !group_fits);
   assign take_grp    = !err_ff && cur_aligned && group_fits;
   assign walk_done   = !take_elem && !take_grp;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish   = (state_ff == S_QUERY) && walk_done && !pend_ff && out_free;

   // sign extension of the registered read data and of the assign value
   assign addend = kind_ff ? {{(TOTAL_W-SUM_W){sum_rd_ff[SUM_W-1]}}, sum_rd_ff}
                           : {{(TOTAL_W-VAL_W){elem_rd_ff[VAL_W-1]}}, elem_rd_ff};
   assign old_ext = {{(SUM_W-VAL_W){elem_rd_ff[VAL_W-1]}}, elem_rd_ff};
   assign new_ext = {{(SUM_W-VAL_W){val_ff[VAL_W-1]}}, val_ff};

   // read addresses follow the cursor
   assign elem_raddr = cur_addr;
   assign sum_raddr  = cur_grp;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cur_in         = cur_ff;
      end_in         = end_ff;
      val_in         = val_ff;
      err_in         = err_ff;
      acc_in         = acc_ff;
      pend_in        = 1'b0;
      kind_in        = kind_ff;
      total_in       = total_ff;
      range_error_in = range_error_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      elem_we        = 1'b0;
      elem_waddr     = cur_addr;
      elem_wdata     = val_ff;
      sum_we         = 1'b0;
      sum_waddr      = cur_grp;
      sum_wdata      = sum_rd_ff + new_ext - old_ext;

      unique case (state_ff)
         S_CLEAR: begin
            // one element and at most one group sum zeroed per cycle
            elem_we    = 1'b1;
            elem_waddr = clr_ff;
            elem_wdata = '0;
            sum_we     = ((ADDR_W+1)'(clr_ff) < (ADDR_W+1)'(GROUPS));
            sum_waddr  = GRP_W'(clr_ff);
            sum_wdata  = '0;
            clr_in     = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(ELEMENTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cur_in = CUR_W'(req_chan.position);
               end_in = CUR_W'(req_chan.range_end);
               val_in = req_chan.value;
               acc_in = '0;
               err_in = (CUR_W'(req_chan.position) > CUR_W'(req_chan.range_end)) ||
                        ((END_W+1)'(req_chan.range_end) > (END_W+1)'(ELEMENTS));
               if (req_chan.op == OP_SUM) begin
                  state_in = S_QUERY;
               end else if ((POS_W+1)'(req_chan.position) < (POS_W+1)'(ELEMENTS)) begin
                  state_in = S_ASG_RD;
               end
               // an assign beyond the array is dropped
            end
         end
         S_ASG_RD: begin
            // old element and its group sum are read at this edge
            state_in = S_ASG_WR;
         end
         S_ASG_WR: begin
            elem_we  = 1'b1;
            sum_we   = 1'b1;
            state_in = S_IDLE;
         end
         S_QUERY: begin
            if (pend_ff) begin
               acc_in = acc_ff + addend;
            end
            if (take_elem) begin
               pend_in = 1'b1;
               kind_in = 1'b0;
               cur_in  = cur_ff + CUR_W'(1);
            end else if (take_grp) begin
               pend_in = 1'b1;
               kind_in = 1'b1;
               cur_in  = cur_ff + CUR_W'(BLOCK_SIZE);
            end
            if (finish) begin
               rsp_valid_in   = 1'b1;
               total_in       = err_ff ? '0 : acc_ff;
               range_error_in = err_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      end_ff         <= end_in;
      val_ff         <= val_in;
      acc_ff         <= acc_in;
      kind_ff        <= kind_in;
      total_ff       <= total_in;
      range_error_ff <= range_error_in;
   end

   // element memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (elem_we) begin
         element_mem[elem_waddr] <= elem_wdata;
      end
      elem_rd_ff <= element_mem[elem_raddr];
   end

   // group sum memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   // memories are written only by the clearing pass and assign write-back
   `BDRS_ASSERT_NOW(a_write_source, elem_we || sum_we, (state_ff == S_CLEAR) || (state_ff == S_ASG_WR))
   // a read in flight is only ever collected by the query walk
   `BDRS_ASSERT_NOW(a_pend_in_query, pend_ff, state_ff == S_QUERY)
   // the walk never steps past range_end
   `BDRS_ASSERT_NOW(a_cursor_bound, (state_ff == S_QUERY) && !err_ff, cur_ff <= end_ff)
   // a rejected range returns zero
   `BDRS_ASSERT_NOW(a_error_zero, rsp_valid_ff && range_error_ff, total_ff == '0)
   // a finished query always lands in the output register
   `BDRS_ASSERT_NEXT(a_finish_loads, finish, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

### sim/tb_block_decomposed_range_sum_unit.sv
`timescale 1ns / 100ps

module tb_block_decomposed_range_sum_unit;
   import bdrs_pkg::*;

   localparam int RANDOM_ITEMS = 600;   // random transactions after the directed table
   localparam int PRELOAD      = 96;    // leading random transactions forced to assigns
   localparam int TAIL_CYCLES  = 120;   // longest walk plus margin, waited out at the end

   // expected outcome of one range sum
   typedef struct packed {
      logic signed [TOTAL_W-1:0] total;
      logic                      range_error;
   } sum_result_type;

   // one row of the directed table; typed rows carry a hand-written result
   typedef struct {
      logic                     op;
      logic [POS_W-1:0]         position;
      logic [END_W-1:0]         range_end;
      logic signed [VAL_W-1:0]  value;
      bit                       typed;
      logic signed [TOTAL_W-1:0] total;
      logic                     range_error;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdrs_req_if req_chan ();
   bdrs_rsp_if rsp_chan ();

   block_decomposed_range_sum_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // mirror of the element array and of the per-group running sums
   logic signed [VAL_W-1:0] element_mirror [ELEMENTS];
   longint                  group_mirror   [GROUPS];

   sum_result_type pending_sums [$];   // range sums accepted but not yet answered
   stim_row_type   directed_rows [$];

   int mismatches   = 0;
   int results_seen = 0;
   int errors_seen  = 0;
   int assigns_sent = 0;
   int sums_sent    = 0;
   int burst_left   = 0;

   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   always #10 clock = ~clock;

   // --------------------------------------------------------------------------
   // predictor: walk head elements up to a group boundary, then whole groups,
   // then the tail elements, never stepping past the right bound
   // --------------------------------------------------------------------------
   function automatic sum_result_type range_total(input int unsigned lo,
                                                  input int unsigned hi);
      sum_result_type r;
      longint      acc;
      int unsigned k;
      r.total       = '0;
      r.range_error = 1'b0;
      if (lo > hi || hi > ELEMENTS) begin
         // reversed or overlong range: zero total, error flag
         r.range_error = 1'b1;
         return r;
      end
      acc = 0;
      k   = lo;
      while (k < hi && (k % BLOCK_SIZE) != 0) begin
         acc += element_mirror[k];
         k++;
      end
      while (k + BLOCK_SIZE <= hi) begin
         acc += group_mirror[k / BLOCK_SIZE];
         k += BLOCK_SIZE;
      end
      while (k < hi) begin
         acc += element_mirror[k];
         k++;
      end
      r.total = acc[TOTAL_W-1:0];
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // drive one transaction, hold it until accepted, then update the mirror or
   // queue the expected sum
   // --------------------------------------------------------------------------
   task automatic send_request(input logic op, input logic [POS_W-1:0] pos,
                               input logic [END_W-1:0] rend,
                               input logic signed [VAL_W-1:0] val, input bit typed,
                               input logic signed [TOTAL_W-1:0] t_total,
                               input logic t_err);
      sum_result_type r;
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.position  <= pos;
      req_chan.range_end <= rend;
      req_chan.value     <= val;
      do @(posedge clock); while (!req_chan.ready);
      if (op == OP_ASSIGN) begin
         // the group sum moves by the difference between new and old element
         group_mirror[pos / BLOCK_SIZE] += longint'(val) - longint'(element_mirror[pos]);
         element_mirror[pos] = val;
         assigns_sent++;
      end else begin
         r = range_total(32'(pos), 32'(rend));
         if (typed) begin
            r.total       = t_total;
            r.range_error = t_err;
         end
         pending_sums.push_back(r);
         sums_sent++;
      end
   endtask

   // sender idling: bursts of random length, random gaps in between
   task automatic sender_gap();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // hold the sender off until every outstanding sum has come back
   task automatic drain_results();
      if (pending_sums.size() != 0) begin
         req_chan.valid <= 1'b0;
         while (pending_sums.size() != 0) @(posedge clock);
      end
   endtask

   task automatic add_row(input logic op, input int unsigned pos, input int unsigned rend,
                          input logic signed [VAL_W-1:0] val, input bit typed,
                          input logic signed [TOTAL_W-1:0] t_total, input logic t_err);
      stim_row_type row;
      row.op          = op;
      row.position    = pos[POS_W-1:0];
      row.range_end   = rend[END_W-1:0];
      row.value       = val;
      row.typed       = typed;
      row.total       = t_total;
      row.range_error = t_err;
      directed_rows.push_back(row);
   endtask

   // --------------------------------------------------------------------------
   // receiver: stall pattern picked afresh whenever its random hold count runs out
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;                        // no stalls
         1: rsp_chan.ready <= ($urandom_range(0, 1) == 1); // coin toss
         2: rsp_chan.ready <= (stall_left[2:0] == 3'd0);   // ready only when the low three bits of stall_left are zero
         default: rsp_chan.ready <= (stall_left > 20);     // long stall at the end
      endcase
   end

   // --------------------------------------------------------------------------
   // result checker: each accepted transaction against the oldest expectation
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      sum_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.range_error) errors_seen++;
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result total=%0d range_error=%0b", $time,
                     rsp_chan.total, rsp_chan.range_error);
            mismatches++;
         end else begin
            want = pending_sums.pop_front();
            if (rsp_chan.total !== want.total) begin
               $display("%0t: total expected %0d actual %0d", $time, want.total,
                        rsp_chan.total);
               mismatches++;
            end
            if (rsp_chan.range_error !== want.range_error) begin
               $display("%0t: range_error expected %0b actual %0b", $time,
                        want.range_error, rsp_chan.range_error);
               mismatches++;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin
      int unsigned lo, hi, blk, pick;
      logic                    op;
      logic signed [VAL_W-1:0] val;

      req_chan.valid     = 1'b0;
      req_chan.op        = OP_ASSIGN;
      req_chan.position  = '0;
      req_chan.range_end = '0;
      req_chan.value     = '0;
      rsp_chan.ready     = 1'b0;
      foreach (element_mirror[i]) element_mirror[i] = '0;
      foreach (group_mirror[i]) group_mirror[i] = 0;

      // freshly cleared array: whole range and last element read as zero
      add_row(OP_SUM, 0, ELEMENTS, 0, 1, 0, 1'b0);
      add_row(OP_SUM, ELEMENTS - 1, ELEMENTS, 0, 1, 0, 1'b0);
      // empty ranges
      add_row(OP_SUM, 5, 5, 0, 1, 0, 1'b0);
      add_row(OP_SUM, 0, 0, 0, 1, 0, 1'b0);
      add_row(OP_SUM, ELEMENTS - 1, ELEMENTS - 1, 32'sh1234_5678, 1, 0, 1'b0);
      // reversed range, right just past the end, all-ones right bound
      add_row(OP_SUM, 10, 3, 0, 1, 0, 1'b1);
      add_row(OP_SUM, 1023, 0, 0, 1, 0, 1'b1);
      add_row(OP_SUM, 0, ELEMENTS + 1, 0, 1, 0, 1'b1);
      add_row(OP_SUM, 1023, 2047, 0, 1, 0, 1'b1);
      // extreme values at the array ends and around a group boundary
      add_row(OP_ASSIGN, 0, 0, 32'sh7FFF_FFFF, 0, 0, 1'b0);
      add_row(OP_ASSIGN, ELEMENTS - 1, 2047, 32'sh8000_0000, 0, 0, 1'b0);
      add_row(OP_ASSIGN, BLOCK_SIZE - 1, 0, -32'sd1, 0, 0, 1'b0);
      add_row(OP_ASSIGN, BLOCK_SIZE, 0, 32'sd1, 0, 0, 1'b0);
      add_row(OP_ASSIGN, 4, 0, 32'sh8000_0000, 0, 0, 1'b0);
      add_row(OP_SUM, 0, ELEMENTS, 0, 0, 0, 1'b0);
      add_row(OP_SUM, 0, BLOCK_SIZE, 0, 0, 0, 1'b0);                   // exactly one group
      add_row(OP_SUM, 1, BLOCK_SIZE - 1, 0, 0, 0, 1'b0);               // inside one group
      add_row(OP_SUM, 3, 5, 0, 0, 0, 1'b0);                            // short, mid-group
      add_row(OP_SUM, BLOCK_SIZE - 1, BLOCK_SIZE + 1, 0, 0, 0, 1'b0);  // straddles a boundary
      add_row(OP_SUM, 30, 1000, 0, 0, 0, 1'b0);                        // head, groups, tail
      add_row(OP_SUM, BLOCK_SIZE, 2 * BLOCK_SIZE, 0, 0, 0, 1'b0);
      // overwrite an element: group sum must follow the difference
      add_row(OP_ASSIGN, 0, 0, -32'sd5, 0, 0, 1'b0);
      add_row(OP_SUM, 0, 1, 0, 0, 0, 1'b0);
      add_row(OP_SUM, 0, ELEMENTS, 0, 0, 0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         sender_gap();
         send_request(directed_rows[i].op, directed_rows[i].position,
                      directed_rows[i].range_end, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].total,
                      directed_rows[i].range_error);
      end
      drain_results();

      // random part: a load of assigns first, then a mix weighted to valid ranges
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_gap();
         if (n == RANDOM_ITEMS / 2) drain_results();

         pick = $urandom_range(0, 99);
         if (pick < 10)      val = 32'sh7FFF_FFFF;
         else if (pick < 20) val = 32'sh8000_0000;
         else if (pick < 25) val = '0;
         else if (pick < 30) val = -32'sd1;
         else                val = $urandom;

         op = (n < PRELOAD || $urandom_range(0, 99) < 45) ? OP_ASSIGN : OP_SUM;
         pick = $urandom_range(0, 99);
         if (op == OP_ASSIGN) begin
            // a fifth of the writes land on a few hot elements
            lo = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
            hi = $urandom_range(0, 2047);
         end else if (pick < 4) begin
            lo = $urandom_range(1, ELEMENTS - 1);
            hi = $urandom_range(0, lo - 1);
         end else if (pick < 8) begin
            lo = $urandom_range(0, ELEMENTS - 1);
            hi = $urandom_range(ELEMENTS + 1, 2047);
         end else if (pick < 30) begin
            blk = $urandom_range(0, GROUPS - 1);
            lo  = blk * BLOCK_SIZE + $urandom_range(0, BLOCK_SIZE - 1);
            hi  = lo + $urandom_range(0, (blk + 1) * BLOCK_SIZE - lo);
         end else if (pick < 55) begin
            lo = $urandom_range(0, ELEMENTS - 1);
            hi = lo + $urandom_range(1, 100);
            if (hi > ELEMENTS) hi = ELEMENTS;
         end else if (pick < 60) begin
            lo = 0;
            hi = ELEMENTS;
         end else begin
            lo = $urandom_range(0, ELEMENTS - 1);
            hi = $urandom_range(lo, ELEMENTS);
         end
         send_request(op, lo[POS_W-1:0], hi[END_W-1:0], val, 0, '0, 1'b0);
      end

      // wind down: everything answered, then one walk's worth of quiet
      req_chan.valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d assigns and %0d range sums under random stalls", assigns_sent,
               sums_sent);
      $display("checked %0d results, %0d of them rejected ranges", results_seen,
               errors_seen);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, sized well beyond the clearing pass and the slowest stalled run
   initial begin
      #12_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/bdrs_pkg.sv
rtl/bdrs_req_if.sv
rtl/bdrs_rsp_if.sv
rtl/block_decomposed_range_sum_unit.sv
sim/tb_block_decomposed_range_sum_unit.sv
